### rtl/core/rbe_pkg.sv
// shared types, constants, helper functions and the step program of the rigid body euler step
// depends on nothing; used by rbe_mul_round and rigid_body_2d_euler_step
package rbe_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int STEP_BITS         = 16;
    localparam int WORD_W            = 32;
    localparam int LIMIT_W           = 31;
    localparam int PROD_W            = 65;
    localparam int STEP_W            = 4;
    localparam int CFG_IDX_W         = 8;

    // reset values of the tick constants (limits and gravity as integer parts before scaling)
    localparam int RST_TIME_STEP  = 1092;
    localparam int RST_FRICTION   = 63069;
    localparam int RST_LIMIT_X_I  = 200;
    localparam int RST_LIMIT_Y_I  = 600;
    localparam int RST_GRAVITY_I  = 600;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 8'd5;

    typedef enum logic [2:0] {
        MA_VX, MA_VY, MA_FX, MA_FY, MA_AX, MA_AY
    } t_mul_a;

    typedef enum logic [1:0] {
        MK_STEP, MK_MASS, MK_FRIC
    } t_mul_k;

    typedef enum logic [3:0] {
        WB_NONE, WB_IMPULSE, WB_POS_X, WB_POS_Y, WB_ACC_X, WB_ACC_Y,
        WB_VEL_X, WB_VEL_Y, WB_FRIC_X, WB_FRIC_Y, WB_FINISH
    } t_wb;

    typedef enum logic [0:0] {
        JC_NONE, JC_NO_FRICTION
    } t_jmp;

    typedef struct packed {
        t_mul_a              mul_a;
        t_mul_k              mul_k;
        logic                frac;   // rescale product by the fraction bits, else by step bits
        t_wb                 wb;
        t_jmp                jmp;
        logic [STEP_W-1:0]   target;
    } t_uword;

    localparam logic [STEP_W-1:0] ST_START  = 4'd0;
    localparam logic [STEP_W-1:0] ST_FINISH = 4'd13;

    function automatic t_uword uw(input t_mul_a a, input t_mul_k k, input logic frac,
                                  input t_wb wb, input t_jmp j,
                                  input logic [STEP_W-1:0] t);
        t_uword w;
        w.mul_a  = a;
        w.mul_k  = k;
        w.frac   = frac;
        w.wb     = wb;
        w.jmp    = j;
        w.target = t;
        return w;
    endfunction

    // step program; a product passes the product and term registers before its term is used
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            4'd0:    w = uw(MA_VX, MK_STEP, 1'b0, WB_IMPULSE, JC_NONE, ST_START);
            4'd1:    w = uw(MA_VX, MK_STEP, 1'b0, WB_NONE,    JC_NONE, ST_START);
            4'd2:    w = uw(MA_VY, MK_STEP, 1'b0, WB_NONE,    JC_NONE, ST_START);
            4'd3:    w = uw(MA_FX, MK_MASS, 1'b1, WB_POS_X,   JC_NONE, ST_START);
            4'd4:    w = uw(MA_FY, MK_MASS, 1'b1, WB_POS_Y,   JC_NONE, ST_START);
            4'd5:    w = uw(MA_VX, MK_STEP, 1'b0, WB_ACC_X,   JC_NONE, ST_START);
            4'd6:    w = uw(MA_AX, MK_STEP, 1'b0, WB_ACC_Y,   JC_NONE, ST_START);
            4'd7:    w = uw(MA_AY, MK_STEP, 1'b0, WB_NONE,    JC_NONE, ST_START);
            4'd8:    w = uw(MA_VX, MK_FRIC, 1'b0, WB_VEL_X,   JC_NONE, ST_START);
            4'd9:    w = uw(MA_VX, MK_FRIC, 1'b0, WB_VEL_Y,   JC_NO_FRICTION, ST_FINISH);
            4'd10:   w = uw(MA_VY, MK_FRIC, 1'b0, WB_NONE,    JC_NONE, ST_START);
            4'd11:   w = uw(MA_VX, MK_FRIC, 1'b0, WB_FRIC_X,  JC_NONE, ST_START);
            4'd12:   w = uw(MA_VX, MK_FRIC, 1'b0, WB_FRIC_Y,  JC_NONE, ST_START);
            4'd13:   w = uw(MA_VX, MK_STEP, 1'b0, WB_FINISH,  JC_NONE, ST_START);
            default: w = uw(MA_VX, MK_STEP, 1'b0, WB_FINISH,  JC_NONE, ST_START);
        endcase
        return w;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] max_v;
        logic signed [PROD_W-1:0] min_v;
        max_v = 65'sd2147483647;
        min_v = -65'sd2147483648;
        if (v > max_v) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < min_v) begin
            return 32'sh8000_0000;
        end
        return v[WORD_W-1:0];
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W:0] mag33(input logic signed [WORD_W-1:0] v);
        logic [WORD_W:0] e;
        e = {v[WORD_W-1], v};
        return v[WORD_W-1] ? (~e + 33'd1) : e;
    endfunction

    // a nonzero value at or beyond the limit takes the limit with its own sign
    function automatic logic signed [WORD_W-1:0] clamp_axis(input logic signed [WORD_W-1:0] v,
                                                            input logic [LIMIT_W-1:0] lim);
        logic [WORD_W-1:0] lim_e;
        lim_e = {1'b0, lim};
        if (v != '0 && {1'b0, lim_e} <= mag33(v)) begin
            return v[WORD_W-1] ? $signed(~lim_e + 32'd1) : $signed(lim_e);
        end
        return v;
    endfunction

endpackage

### rtl/core/rbe_mul_round.sv
// shared multiplier with a rounding and saturation stage behind it
// depends on rbe_pkg; instanced by rigid_body_2d_euler_step
module rbe_mul_round #(
    parameter int FRACTION_BITS = rbe_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic signed [rbe_pkg::WORD_W-1:0]    i_a,
    input  logic        [rbe_pkg::WORD_W-1:0]    i_k,
    input  logic                                 i_frac,
    output logic signed [rbe_pkg::WORD_W-1:0]    o_term
);

    localparam int PW = rbe_pkg::PROD_W;
    localparam logic signed [PW-1:0] HALF_F = PW'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [PW-1:0] HALF_S = PW'(1) <<< (rbe_pkg::STEP_BITS - 1);

    logic signed [PW-1:0]             r_prod;
    logic                             r_frac;
    logic signed [rbe_pkg::WORD_W-1:0] r_term;

    logic signed [PW-1:0] n_prod;
    logic signed [PW-1:0] neg_e;
    logic signed [PW-1:0] sum_f;
    logic signed [PW-1:0] sum_s;
    logic signed [PW-1:0] sh_f;
    logic signed [PW-1:0] sh_s;

    always_comb begin
        n_prod = PW'(i_a) * PW'($signed({1'b0, i_k}));
    end

    // ties away from zero: a negative product rounds up from one below the half
    always_comb begin
        neg_e = $signed({{(PW-1){1'b0}}, r_prod[PW-1]});
        sum_f = r_prod + HALF_F - neg_e;
        sum_s = r_prod + HALF_S - neg_e;
        sh_f  = sum_f >>> FRACTION_BITS;
        sh_s  = sum_s >>> rbe_pkg::STEP_BITS;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_frac <= i_frac;
        r_term <= rbe_pkg::sat32(r_frac ? sh_f : sh_s);
    end

    assign o_term = r_term;

endmodule

### rtl/core/rigid_body_2d_euler_step.sv
// Explicit Euler step for one 2D body per request: impulse, position move, force and
// carried gravity, contact, ground friction and clamp, all signed fixed point with
// FRACTION_BITS fraction bits and saturating. A short step program in rbe_pkg drives
// one shared 32x33 multiplier whose product and term registers lie between an operand
// and its rounded term. A request is taken only while no other is in flight; it runs
// steps 0 to 9 and 13, or 0 to 13 when ground friction applies, and a new request waits
// until it is done. The result sits in an output register, so the next request runs
// while it waits, and the last step holds only if that register is still full.
// Configuration writes are always ready; the user must keep them to idle periods (not enforced).
// depends on rbe_pkg and rbe_mul_round
module rigid_body_2d_euler_step #(
    parameter int FRACTION_BITS = rbe_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rbe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // force_x, force_y, impulse_x, impulse_y, position_x, position_y (32 bits each)
    input  logic [191:0]                      s_axis_tdata,
    // grounded, blocked_up
    input  logic [1:0]                        s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // next_position_x, next_position_y, next_velocity_x, next_velocity_y (32 bits each)
    output logic [127:0]                      m_axis_tdata
);

    localparam int W  = rbe_pkg::WORD_W;
    localparam int LW = rbe_pkg::LIMIT_W;
    localparam int SNAP_LIMIT = ((1 << FRACTION_BITS) * 2 + 10) / 20;
    localparam logic [W-1:0]  RST_INV_MASS = W'(64'd1 << FRACTION_BITS);
    localparam logic [LW-1:0] RST_LIMIT_X  = LW'(64'(rbe_pkg::RST_LIMIT_X_I) << FRACTION_BITS);
    localparam logic [LW-1:0] RST_LIMIT_Y  = LW'(64'(rbe_pkg::RST_LIMIT_Y_I) << FRACTION_BITS);
    localparam logic [LW-1:0] RST_GRAVITY  = LW'(64'(rbe_pkg::RST_GRAVITY_I) << FRACTION_BITS);

    // configuration
    logic [W-1:0]  r_inv_mass;
    logic [15:0]   r_time_step;
    logic [15:0]   r_friction;
    logic [LW-1:0] r_limit_x;
    logic [LW-1:0] r_limit_y;
    logic [LW-1:0] r_gravity;

    // kept state
    logic signed [W-1:0] r_vx, r_vy, r_cg;
    logic signed [W-1:0] n_vx, n_vy, n_cg;

    // working registers
    logic signed [W-1:0] r_fx, r_fy, r_ix, r_iy, r_px, r_py, r_ax, r_ay;
    logic signed [W-1:0] n_px, n_py, n_ax, n_ay;
    logic                r_gnd, r_blk;

    // sequencer
    logic                         r_busy, n_busy;
    logic [rbe_pkg::STEP_W-1:0]   r_step, n_step;
    rbe_pkg::t_uword              uword;

    // result register
    logic                r_out_valid, n_out_valid;
    logic signed [W-1:0] r_out_px, r_out_py, r_out_vx, r_out_vy;

    logic                s_accept;
    logic                out_free;
    logic                finish;
    logic                stall;
    logic                jump;
    logic [W:0]          vx_mag;
    logic                fric_cand;
    logic                snap_hit;
    logic signed [W-1:0] mul_a;
    logic [W-1:0]        mul_k;
    logic signed [W-1:0] term;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_busy;
    assign s_accept      = s_axis_tvalid && !r_busy;
    assign uword         = rbe_pkg::ucode(r_step);

    assign out_free = !r_out_valid || m_axis_tready;
    assign finish   = r_busy && (uword.wb == rbe_pkg::WB_FINISH);
    assign stall    = finish && !out_free;

    // friction applies on the ground with horizontal motion; a slow body's horizontal velocity snaps to zero
    assign vx_mag    = rbe_pkg::mag33(r_vx);
    assign fric_cand = r_gnd && (r_vx != '0);
    assign snap_hit  = fric_cand && (vx_mag < (W+1)'(SNAP_LIMIT));
    assign jump      = (uword.jmp == rbe_pkg::JC_NO_FRICTION) && (!fric_cand || snap_hit);

    always_comb begin
        unique case (uword.mul_a)
            rbe_pkg::MA_VX: mul_a = r_vx;
            rbe_pkg::MA_VY: mul_a = r_vy;
            rbe_pkg::MA_FX: mul_a = r_fx;
            rbe_pkg::MA_FY: mul_a = r_fy;
            rbe_pkg::MA_AX: mul_a = r_ax;
            rbe_pkg::MA_AY: mul_a = r_ay;
            default:        mul_a = r_vx;
        endcase
        unique case (uword.mul_k)
            rbe_pkg::MK_STEP: mul_k = {16'd0, r_time_step};
            rbe_pkg::MK_MASS: mul_k = r_inv_mass;
            rbe_pkg::MK_FRIC: mul_k = {16'd0, r_friction};
            default:          mul_k = {16'd0, r_time_step};
        endcase
    end

    rbe_mul_round #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_k    (mul_k),
        .i_frac (uword.frac),
        .o_term (term)
    );

    // sequencer next state
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (s_accept) begin
                n_busy = 1'b1;
                n_step = rbe_pkg::ST_START;
            end
        end else if (!stall) begin
            if (finish) begin
                n_busy = 1'b0;
                n_step = rbe_pkg::ST_START;
            end else if (jump) begin
                n_step = uword.target;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    // datapath write-back
    always_comb begin
        n_vx = r_vx;
        n_vy = r_vy;
        n_cg = r_cg;
        n_px = r_px;
        n_py = r_py;
        n_ax = r_ax;
        n_ay = r_ay;
        if (r_busy) begin
            unique case (uword.wb)
                rbe_pkg::WB_NONE: begin
                end
                rbe_pkg::WB_IMPULSE: begin
                    n_vx = rbe_pkg::sat_add(r_vx, r_ix);
                    n_vy = rbe_pkg::sat_add(r_vy, r_iy);
                end
                rbe_pkg::WB_POS_X: n_px = rbe_pkg::sat_add(r_px, term);
                rbe_pkg::WB_POS_Y: n_py = rbe_pkg::sat_add(r_py, term);
                rbe_pkg::WB_ACC_X: n_ax = term;
                rbe_pkg::WB_ACC_Y: begin
                    // gravity from the previous request, then carried for the next
                    n_ay = rbe_pkg::sat_add(term, r_cg);
                    n_cg = (!r_gnd || r_blk) ? $signed({1'b0, r_gravity}) : '0;
                    if (r_gnd || r_blk) begin
                        n_vy = '0;
                    end
                end
                rbe_pkg::WB_VEL_X: n_vx = rbe_pkg::sat_add(r_vx, term);
                rbe_pkg::WB_VEL_Y: begin
                    n_vy = rbe_pkg::sat_add(r_vy, term);
                    if (snap_hit) begin
                        n_vx = '0;
                    end
                end
                rbe_pkg::WB_FRIC_X: n_vx = term;
                rbe_pkg::WB_FRIC_Y: n_vy = term;
                rbe_pkg::WB_FINISH: begin
                    if (out_free) begin
                        n_vx = rbe_pkg::clamp_axis(r_vx, r_limit_x);
                        n_vy = rbe_pkg::clamp_axis(r_vy, r_limit_y);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (finish && out_free) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= rbe_pkg::ST_START;
            r_out_valid <= 1'b0;
            r_vx        <= '0;
            r_vy        <= '0;
            r_cg        <= '0;
            r_inv_mass  <= RST_INV_MASS;
            r_time_step <= 16'(rbe_pkg::RST_TIME_STEP);
            r_friction  <= 16'(rbe_pkg::RST_FRICTION);
            r_limit_x   <= RST_LIMIT_X;
            r_limit_y   <= RST_LIMIT_Y;
            r_gravity   <= RST_GRAVITY;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_vx        <= n_vx;
            r_vy        <= n_vy;
            r_cg        <= n_cg;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rbe_pkg::CFG_INV_MASS:  r_inv_mass  <= i_cfg_data;
                    rbe_pkg::CFG_TIME_STEP: r_time_step <= i_cfg_data[15:0];
                    rbe_pkg::CFG_FRICTION:  r_friction  <= i_cfg_data[15:0];
                    rbe_pkg::CFG_LIMIT_X:   r_limit_x   <= i_cfg_data[LW-1:0];
                    rbe_pkg::CFG_LIMIT_Y:   r_limit_y   <= i_cfg_data[LW-1:0];
                    rbe_pkg::CFG_GRAVITY:   r_gravity   <= i_cfg_data[LW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_fx  <= s_axis_tdata[31:0];
            r_fy  <= s_axis_tdata[63:32];
            r_ix  <= s_axis_tdata[95:64];
            r_iy  <= s_axis_tdata[127:96];
            r_px  <= s_axis_tdata[159:128];
            r_py  <= s_axis_tdata[191:160];
            r_gnd <= s_axis_tuser[0];
            r_blk <= s_axis_tuser[1];
        end else begin
            r_px <= n_px;
            r_py <= n_py;
        end
        r_ax <= n_ax;
        r_ay <= n_ay;
        if (finish && out_free) begin
            r_out_px <= r_px;
            r_out_py <= r_py;
            r_out_vx <= n_vx;
            r_out_vy <= n_vy;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_vy, r_out_vx, r_out_py, r_out_px};

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_busy && r_step == rbe_pkg::ST_START))
        else $error("accepted request did not start the program");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> (r_busy && r_step == rbe_pkg::ST_FINISH && r_out_valid))
        else $error("last step left while the result register was full");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= rbe_pkg::ST_FINISH))
        else $error("step counter beyond the program");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_out_valid)
        else $error("request finished without a result");

    a_gravity_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> (r_cg == '0 || r_cg == $signed({1'b0, r_gravity})))
        else $error("carried gravity neither zero nor the configured value");
`endif

endmodule
